// ===== design/pcsg_pkg.sv =====
// Shared types, constants and helpers of the packet classifier with SYN guard.
`default_nettype none
package pcsg_pkg;

  localparam int STAT_SLOTS    = 256;
  localparam int STAT_AW       = $clog2(STAT_SLOTS);
  localparam int TRACK_ENTRIES = 1024;
  localparam int TRACK_WAYS    = 4;
  localparam int TRACK_SETS    = TRACK_ENTRIES / TRACK_WAYS;
  localparam int TRK_AW        = $clog2(TRACK_SETS);

  localparam logic [31:0] MIX_MULT        = 32'h045D_9F3B;
  localparam logic [15:0] ETH_IPV4        = 16'h0800;
  localparam logic [15:0] ETH_IPV6        = 16'h86DD;
  localparam logic [15:0] ETH_ARP         = 16'h0806;
  localparam logic [7:0]  KEY_ARP         = 8'hFE;
  localparam logic [7:0]  KEY_OTHER       = 8'hFF;
  localparam logic [7:0]  SLOT_TOTAL      = 8'h00;
  localparam logic [7:0]  PROTO_TCP       = 8'd6;
  localparam logic [3:0]  MIN_IHL         = 4'd5;
  localparam logic [1:0]  AGE_MAX         = 2'd3;
  localparam logic [15:0] SYN_LIMIT_RESET = 16'd10;

  localparam logic OP_FRAME     = 1'b0;
  localparam logic OP_READ      = 1'b1;
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_STATS   = 1'b1;
  localparam logic REG_SYN_LIMIT = 1'b0;
  localparam logic REG_GUARD_EN  = 1'b1;

  typedef struct packed {
    logic [63:0] drops;
    logic [63:0] bytes;
    logic [63:0] packets;
  } stat_row_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  age;
    logic [31:0] source;
    logic [63:0] count;
  } trk_way_t;

  typedef trk_way_t [TRACK_WAYS-1:0] trk_row_t;

  // work handed from the parser to the update engine
  typedef struct packed {
    logic               read;
    logic [STAT_AW-1:0] slot;
    logic               drop;
    logic [7:0]         key;
    logic               counted;
    logic [15:0]        len;
    logic               syn;
    logic [31:0]        src;
  } pcsg_job_t;

  typedef enum logic [3:0] {
    E_IDLE, E_MUL, E_TADR, E_TUPD, E_SADR, E_SKEY, E_SZERO, E_RADR, E_RDATA, E_DONE
  } eng_state_t;

  function automatic logic [31:0] mix_pre(input logic [31:0] a);
    return a ^ (a >> 16);
  endfunction

  function automatic logic [TRK_AW-1:0] mix_set(input logic [31:0] p);
    logic [31:0] x;
    x = p ^ (p >> 16);
    return x[TRK_AW-1:0]; // set count is a power of two
  endfunction

endpackage
`default_nettype wire

// ===== design/packet_classifier_syn_guard.sv =====
// Top level: stream ports, APB register file, parser and update engine.
//
//  channel | dir | handshake          | content
//  s_*     | in  | s_tvalid/s_tready  | frame bytes and statistics read requests
//  m_*     | out | m_tvalid/m_tready  | frame verdicts and statistics read data
//  apb     | in  | psel&penable&pwrite| syn_limit @0x0, syn_guard_enable @0x4
//
// Frame bytes that do not end a frame are taken every cycle.
// A frame end or a read is taken only while the engine is idle; it then
// busies the engine until E_DONE: reads pass E_RADR, E_RDATA; counted frames
// E_SADR, E_SKEY (not for class 0), E_SZERO; tracked bare SYNs E_MUL, E_TADR,
// E_TUPD first; bounded by the serial read-modify-write on the two memories.
// The output register lets the engine start the next transfer while a
// result waits; a stalled m_tready holds the engine in its final state.
// Reset is synchronous; no clearing pass: per-row valid flops mark both stores.
`default_nettype none
module packet_classifier_syn_guard
  import pcsg_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [15:0]  s_tdata,   // frame_byte[7:0], slot_index[15:8]
  input  wire logic         s_tuser,   // opcode
  input  wire logic         s_tlast,   // frame_end
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic      [207:0] m_tdata,   // verdict[0], class_key[8:1], counted[9],
                                       // packet_total[73:10], byte_total[137:74],
                                       // drop_total[201:138], zero pad
  output logic              m_tuser,   // result_kind
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);
  logic [15:0] syn_limit;
  logic        syn_guard_enable;
  logic        s_fire, ends_item, idle, start;
  pcsg_job_t   job;
  logic        o_drop, o_counted;
  logic [7:0]  o_key;
  logic [63:0] o_pk, o_by, o_dr;

  assign pready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      syn_limit        <= SYN_LIMIT_RESET;
      syn_guard_enable <= 1'b1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_SYN_LIMIT: syn_limit        <= pwdata[15:0];
        REG_GUARD_EN:  syn_guard_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SYN_LIMIT: prdata = {16'd0, syn_limit};
      REG_GUARD_EN:  prdata = {31'd0, syn_guard_enable};
      default:       prdata = '0;
    endcase
  end

  // mid-frame bytes never wait; ends and reads wait for the engine
  assign ends_item = (s_tuser == OP_READ) || s_tlast;
  assign s_tready  = !ends_item || idle;
  assign s_fire    = s_tvalid && s_tready;
  assign start     = s_fire && ends_item;

  pcsg_parser u_parser (
    .clk, .rst,
    .advance(s_fire && s_tuser == OP_FRAME),
    .opcode(s_tuser), .frame_byte(s_tdata[7:0]), .frame_end(s_tlast),
    .slot_index(s_tdata[15:8]), .syn_guard_enable, .job
  );

  pcsg_engine u_engine (
    .clk, .rst, .start, .job_in(job), .syn_limit, .idle,
    .out_valid(m_tvalid), .out_take(m_tready), .out_kind(m_tuser),
    .out_drop(o_drop), .out_key(o_key), .out_counted(o_counted),
    .out_packets(o_pk), .out_bytes(o_by), .out_drops(o_dr)
  );

  assign m_tdata = {6'd0, o_dr, o_by, o_pk, o_counted, o_key, o_drop};
endmodule
`default_nettype wire

// ===== design/pcsg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pcsg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/pcsg_parser.sv =====
// Byte-wise header parser and end-of-frame classifier.
`default_nettype none
module pcsg_parser
  import pcsg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        advance,
  input  wire logic        opcode,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        frame_end,
  input  wire logic [7:0]  slot_index,
  input  wire logic        syn_guard_enable,
  output pcsg_job_t        job
);
  logic [15:0] byte_offset, ether_type;
  logic [3:0]  header_words;
  logic [7:0]  l4_protocol, tcp_flag_bits;
  logic [31:0] source_address;

  logic [15:0] ether_type_next;
  logic [3:0]  header_words_next;
  logic [7:0]  l4_protocol_next, tcp_flag_bits_next;
  logic [31:0] source_address_next;
  logic [15:0] tcp_off, tcp_min, len;
  logic        is_v4;

  always_comb begin
    ether_type_next     = ether_type;
    header_words_next   = header_words;
    l4_protocol_next    = l4_protocol;
    source_address_next = source_address;
    tcp_flag_bits_next  = tcp_flag_bits;
    if (byte_offset == 16'd12) begin
      ether_type_next = {frame_byte, 8'h00};
    end else if (byte_offset == 16'd13) begin
      ether_type_next = ether_type | {8'h00, frame_byte};
    end else if (byte_offset == 16'd14) begin
      header_words_next = frame_byte[3:0];
    end
    tcp_off = 16'd27 + {10'd0, header_words_next, 2'b00};
    tcp_min = 16'd34 + {10'd0, header_words_next, 2'b00};
    if (ether_type_next == ETH_IPV6 && byte_offset == 16'd20) begin
      l4_protocol_next = frame_byte;
    end
    if (ether_type_next == ETH_IPV4 && byte_offset >= 16'd14) begin
      if (byte_offset == 16'd23) begin
        l4_protocol_next = frame_byte;
      end
      if (byte_offset >= 16'd26 && byte_offset <= 16'd29) begin
        source_address_next = {source_address[23:0], frame_byte};
      end
      if (header_words_next >= MIN_IHL && byte_offset == tcp_off) begin
        tcp_flag_bits_next = frame_byte;
      end
    end
    len   = (byte_offset == 16'hFFFF) ? 16'hFFFF : byte_offset + 16'd1;
    is_v4 = ether_type_next == ETH_IPV4;

    job         = '0;
    job.read    = opcode == OP_READ;
    job.slot    = slot_index[STAT_AW-1:0];
    job.len     = len;
    job.src     = source_address_next;
    if (len < 16'd14) begin
      job.drop = 1'b1;
    end else if (is_v4) begin
      if (len < 16'd34 || header_words_next < MIN_IHL) begin
        job.drop = 1'b1;
      end else begin
        job.key     = l4_protocol_next;
        job.counted = 1'b1;
        job.syn     = l4_protocol_next == PROTO_TCP && len >= tcp_min &&
                      tcp_flag_bits_next[1] && !tcp_flag_bits_next[4] && syn_guard_enable;
      end
    end else if (ether_type_next == ETH_IPV6) begin
      if (len < 16'd54) begin
        job.drop = 1'b1;
      end else begin
        job.key     = l4_protocol_next;
        job.counted = 1'b1;
      end
    end else begin
      job.key     = (ether_type_next == ETH_ARP) ? KEY_ARP : KEY_OTHER;
      job.counted = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (advance && frame_end)) begin
      byte_offset    <= '0;
      ether_type     <= '0;
      header_words   <= '0;
      l4_protocol    <= '0;
      source_address <= '0;
      tcp_flag_bits  <= '0;
    end else if (advance) begin
      ether_type     <= ether_type_next;
      header_words   <= header_words_next;
      l4_protocol    <= l4_protocol_next;
      source_address <= source_address_next;
      tcp_flag_bits  <= tcp_flag_bits_next;
      if (byte_offset != 16'hFFFF) begin
        byte_offset <= byte_offset + 16'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/pcsg_engine.sv =====
// End-of-frame engine: SYN tracker and statistics read-modify-write, result register.
`default_nettype none
module pcsg_engine
  import pcsg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  pcsg_job_t        job_in,
  input  wire logic [15:0] syn_limit,
  output logic             idle,
  output logic             out_valid,
  input  wire logic        out_take,
  output logic             out_kind,
  output logic             out_drop,
  output logic [7:0]       out_key,
  output logic             out_counted,
  output logic [63:0]      out_packets,
  output logic [63:0]      out_bytes,
  output logic [63:0]      out_drops
);
  eng_state_t state, state_next;
  pcsg_job_t  job;
  logic [31:0] prod;
  logic [TRK_AW-1:0] trk_set;

  // statistics store
  logic [STAT_SLOTS-1:0] stat_valid;
  logic                  stat_rv;
  logic                  stat_we;
  logic [STAT_AW-1:0]    stat_waddr, stat_raddr;
  stat_row_t             stat_wdata, stat_rdata, stat_eff;
  logic [63:0]           pk_inc, by_inc, dr_inc;
  logic [63:0]           rd_pk, rd_by, rd_dr;

  // tracker store, one row per set
  logic [TRACK_SETS-1:0] trk_valid;
  logic                  trk_rv;
  logic                  trk_we;
  trk_row_t              trk_rdata, trk_eff, trk_wdata;
  logic [TRK_AW-1:0]     trk_raddr;
  logic                  hit, free_found;
  logic [$clog2(TRACK_WAYS+1)-1:0] hit_way, free_way, old_way, way;
  logic [1:0]            oldest;
  logic [63:0]           cnt_new;
  logic                  launch;

  pcsg_ram #(.WIDTH($bits(stat_row_t)), .DEPTH(STAT_SLOTS)) u_stat_ram (
    .clk, .we(stat_we), .waddr(stat_waddr), .wdata(stat_wdata),
    .raddr(stat_raddr), .rdata(stat_rdata)
  );

  pcsg_ram #(.WIDTH($bits(trk_row_t)), .DEPTH(TRACK_SETS)) u_trk_ram (
    .clk, .we(trk_we), .waddr(trk_set), .wdata(trk_wdata),
    .raddr(trk_raddr), .rdata(trk_rdata)
  );

  assign idle     = state == E_IDLE;
  assign stat_eff = stat_rv ? stat_rdata : '0;
  assign trk_eff  = trk_rv ? trk_rdata : '0;
  assign trk_raddr = mix_set(prod);
  assign launch   = (state == E_DONE) && (!out_valid || out_take);

  // key 0 shares the total slot: that slot takes both updates at once
  always_comb begin
    if (job.key == SLOT_TOTAL) begin
      pk_inc = 64'd2;
      by_inc = {47'd0, job.len, 1'b0};
      dr_inc = {62'd0, job.drop, 1'b0};
    end else begin
      pk_inc = 64'd1;
      by_inc = {48'd0, job.len};
      dr_inc = {63'd0, job.drop};
    end
  end

  // way selection: hit, else first free way, else first oldest way
  always_comb begin
    hit        = 1'b0;
    hit_way    = '0;
    free_found = 1'b0;
    free_way   = '0;
    old_way    = '0;
    oldest     = '0;
    for (int w = 0; w < TRACK_WAYS; w++) begin
      if (!hit && trk_eff[w].valid && trk_eff[w].source == job.src) begin
        hit     = 1'b1;
        hit_way = ($clog2(TRACK_WAYS+1))'(w);
      end
      if (!free_found && !trk_eff[w].valid) begin
        free_found = 1'b1;
        free_way   = ($clog2(TRACK_WAYS+1))'(w);
      end
      if (trk_eff[w].age > oldest) begin
        oldest  = trk_eff[w].age;
        old_way = ($clog2(TRACK_WAYS+1))'(w);
      end
    end
    way = hit ? hit_way : (free_found ? free_way : old_way);
    cnt_new = '0;
    trk_wdata = trk_eff;
    for (int w = 0; w < TRACK_WAYS; w++) begin
      if (($clog2(TRACK_WAYS+1))'(w) == way) begin
        cnt_new = hit ? trk_eff[w].count + 64'd1 : 64'd1;
        trk_wdata[w].valid  = 1'b1;
        trk_wdata[w].age    = '0;
        trk_wdata[w].source = job.src;
        trk_wdata[w].count  = cnt_new;
      end else if (trk_eff[w].valid && trk_eff[w].age < AGE_MAX) begin
        trk_wdata[w].age = trk_eff[w].age + 2'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    stat_we    = 1'b0;
    stat_waddr = SLOT_TOTAL;
    stat_raddr = SLOT_TOTAL;
    stat_wdata = stat_eff;
    trk_we     = 1'b0;
    unique case (state)
      E_IDLE: begin
        if (start) begin
          priority if (job_in.read)    state_next = E_RADR;
          else if (job_in.syn)         state_next = E_MUL;
          else if (job_in.counted)     state_next = E_SADR;
          else                         state_next = E_DONE;
        end
      end
      E_MUL:  state_next = E_TADR;
      E_TADR: state_next = E_TUPD;
      E_TUPD: begin
        trk_we     = 1'b1;
        state_next = E_SADR;
      end
      E_SADR: begin
        stat_raddr = job.key;
        state_next = (job.key == SLOT_TOTAL) ? E_SZERO : E_SKEY;
      end
      E_SKEY: begin
        stat_we            = 1'b1;
        stat_waddr         = job.key;
        stat_wdata.packets = stat_eff.packets + 64'd1;
        stat_wdata.bytes   = stat_eff.bytes + {48'd0, job.len};
        stat_wdata.drops   = stat_eff.drops + {63'd0, job.drop};
        state_next         = E_SZERO;
      end
      E_SZERO: begin
        stat_we            = 1'b1;
        stat_wdata.packets = stat_eff.packets + pk_inc;
        stat_wdata.bytes   = stat_eff.bytes + by_inc;
        stat_wdata.drops   = stat_eff.drops + dr_inc;
        state_next         = E_DONE;
      end
      E_RADR: begin
        stat_raddr = job.slot;
        state_next = E_RDATA;
      end
      E_RDATA: state_next = E_DONE;
      E_DONE:  if (launch) state_next = E_IDLE;
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat_valid <= '0;
      trk_valid  <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (stat_we) stat_valid[stat_waddr] <= 1'b1;
      if (trk_we)  trk_valid[trk_set]     <= 1'b1;
      if (launch)        out_valid <= 1'b1;
      else if (out_take) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    stat_rv <= stat_valid[stat_raddr];
    trk_rv  <= trk_valid[trk_raddr];
    if (start && idle) job <= job_in;
    if (state == E_MUL)  prod <= mix_pre(job.src) * MIX_MULT;
    if (state == E_TADR) trk_set <= trk_raddr;
    if (state == E_TUPD) job.drop <= hit && (cnt_new > {48'd0, syn_limit});
    // read data is staged so a waiting result stays intact
    if (state == E_RDATA) begin
      rd_pk <= stat_eff.packets;
      rd_by <= stat_eff.bytes;
      rd_dr <= stat_eff.drops;
    end
    if (launch) begin
      out_kind    <= job.read ? KIND_STATS : KIND_VERDICT;
      out_drop    <= !job.read && job.drop;
      out_key     <= job.read ? 8'd0 : job.key;
      out_counted <= !job.read && job.counted;
      out_packets <= job.read ? rd_pk : '0;
      out_bytes   <= job.read ? rd_by : '0;
      out_drops   <= job.read ? rd_dr : '0;
    end
  end
endmodule
`default_nettype wire

// ===== design/pcsg_checker.sv =====
// Port-level checker for the classifier, bound to the top level.
`default_nettype none
module pcsg_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic         s_tuser,
  input wire logic         s_tlast,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [207:0] m_tdata,
  input wire logic         m_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser || s_tlast) |=>
      !(s_tvalid && s_tready && (s_tuser || s_tlast)))
    else $error("frame end or read taken while engine busy");

  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[9:0] == 10'd0)
    else $error("read result carries verdict fields");

  a_verdict_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[207:10] == '0)
    else $error("verdict carries totals");

  a_uncounted: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && !m_tdata[9] |-> m_tdata[0] && m_tdata[8:1] == 8'd0)
    else $error("uncounted frame not dropped with class 0");
endmodule

bind packet_classifier_syn_guard pcsg_checker u_pcsg_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .s_tuser(s_tuser), .s_tlast(s_tlast), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
